### rtl/todga_pkg.sv
// ============================================================================
// todga_pkg
// Shared types, constants and helper functions for the tiled dot-general
// operand address generator.
// ============================================================================
package todga_pkg;

    localparam int RankLimit = 4;
    localparam int NumDims   = 4;
    localparam int IdxW      = 16;
    localparam int FlatW     = 24;
    localparam int TileW     = 32;
    localparam int OffW      = 10;
    localparam int DivBits   = 4;
    localparam int DivSteps  = FlatW / DivBits;
    localparam int DivPasses = 4;
    localparam int DivStages = DivSteps * DivPasses;

    typedef logic [IdxW-1:0] idx_t;
    typedef idx_t [NumDims-1:0] idx_vec_t;

    // Work carried down the divider pipeline.
    typedef struct packed {
        logic [FlatW-1:0] num;
        logic [IdxW-1:0]  rem;
        idx_vec_t         cidx;
        idx_vec_t         lidx;
        idx_vec_t         ridx;
    } work_t;

    typedef struct packed {
        logic [63:0] lext;
        logic [63:0] rext;
        logic [17:0] rac;
        logic [23:0] lmap;
        logic [23:0] rmap;
        logic [31:0] lgrid;
        logic [31:0] rgrid;
    } cfg_t;

    typedef enum logic [2:0] {
        RegLeftExt   = 3'd0,
        RegRightExt  = 3'd1,
        RegRanks     = 3'd2,
        RegLeftMap   = 3'd3,
        RegRightMap  = 3'd4,
        RegLeftGrid  = 3'd5,
        RegRightGrid = 3'd6
    } reg_idx_t;

    localparam logic [1:0] GrpBatch    = 2'd0;
    localparam logic [1:0] GrpOuter    = 2'd1;
    localparam logic [1:0] GrpContract = 2'd2;

    localparam logic [2:0] PosLeftRank  = 3'd0;
    localparam logic [2:0] PosRightRank = 3'd1;
    localparam logic [2:0] PosBatch     = 3'd2;
    localparam logic [2:0] PosLeftOut   = 3'd3;
    localparam logic [2:0] PosRightOut  = 3'd4;
    localparam logic [2:0] PosContract  = 3'd5;

    // Extent of a dimension; a zero extent behaves as one.
    function automatic idx_t extent_at(logic [63:0] ext, logic [1:0] dim);
        idx_t e;
        e = ext[{dim, 4'd0} +: IdxW];
        return (e == '0) ? idx_t'(1) : e;
    endfunction

    function automatic logic [2:0] field_at(logic [17:0] rac, logic [2:0] pos);
        logic [17:0] s;
        s = rac >> (5'(pos) * 5'd3);
        return s[2:0];
    endfunction

    // Slot count, saturated to the number of slots.
    function automatic logic [2:0] count_at(logic [17:0] rac, logic [2:0] pos);
        logic [2:0] c;
        c = field_at(rac, pos);
        return (c > 3'(NumDims)) ? 3'(NumDims) : c;
    endfunction

    // Operand rank, clamped between two and the rank limit.
    function automatic logic [2:0] rank_at(logic [17:0] rac, logic [2:0] pos);
        logic [2:0] r;
        r = field_at(rac, pos);
        if (r < 3'd2) begin
            r = 3'd2;
        end else if (r > 3'(RankLimit)) begin
            r = 3'(RankLimit);
        end
        return r;
    endfunction

    function automatic logic [1:0] map_at(logic [23:0] map, logic [1:0] grp,
                                          logic [1:0] slot);
        logic [23:0] s;
        s = map >> {grp, slot, 1'b0};
        return s[1:0];
    endfunction

    // Four steps of restoring division: dividend bits leave num at the top,
    // quotient bits enter at the bottom.
    function automatic logic [FlatW+IdxW-1:0] div_step(logic [FlatW-1:0] num,
                                                        logic [IdxW-1:0] rem,
                                                        idx_t d);
        logic [IdxW:0]    t;
        logic [FlatW-1:0] n;
        logic [IdxW-1:0]  r;
        n = num;
        r = rem;
        for (int k = 0; k < DivBits; k++) begin
            t = {r, n[FlatW-1]};
            n = {n[FlatW-2:0], 1'b0};
            if (t >= {1'b0, d}) begin
                t    = t - {1'b0, d};
                n[0] = 1'b1;
            end
            r = t[IdxW-1:0];
        end
        return {n, r};
    endfunction

endpackage

### rtl/todga_map.sv
// ============================================================================
// todga_map
// Entry stage: places output indices on batch and outer operand dimensions.
// ============================================================================
module todga_map import todga_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  logic             in_valid,
    input  idx_vec_t         outi,
    input  logic [FlatW-1:0] flat,
    input  cfg_t             cfg,
    output logic             out_valid,
    output work_t            out_work
);

    logic  valid_reg;
    work_t work_reg;
    work_t work_next;

    always_comb begin
        logic [2:0] batch;
        logic [2:0] lout;
        logic [2:0] rout;
        logic [3:0] od;
        batch = count_at(cfg.rac, PosBatch);
        lout  = count_at(cfg.rac, PosLeftOut);
        rout  = count_at(cfg.rac, PosRightOut);
        work_next      = '0;
        work_next.num  = flat;
        for (int i = 0; i < NumDims; i++) begin
            if (3'(i) < batch) begin
                work_next.lidx[map_at(cfg.lmap, GrpBatch, 2'(i))] = outi[i];
                work_next.ridx[map_at(cfg.rmap, GrpBatch, 2'(i))] = outi[i];
            end
        end
        for (int i = 0; i < NumDims; i++) begin
            od = 4'(batch) + 4'(i);
            if (3'(i) < lout) begin
                work_next.lidx[map_at(cfg.lmap, GrpOuter, 2'(i))] =
                    (od < 4'(NumDims)) ? outi[od[1:0]] : '0;
            end
        end
        for (int i = 0; i < NumDims; i++) begin
            od = 4'(batch) + 4'(lout) + 4'(i);
            if (3'(i) < rout) begin
                work_next.ridx[map_at(cfg.rmap, GrpOuter, 2'(i))] =
                    (od < 4'(NumDims)) ? outi[od[1:0]] : '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            work_reg <= work_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_work  = work_reg;

endmodule

### rtl/todga_div.sv
// ============================================================================
// todga_div
// Pipelined mixed-radix split of the flat contraction position.
// ============================================================================
module todga_div import todga_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  adv,
    input  logic  in_valid,
    input  work_t in_work,
    input  cfg_t  cfg,
    output logic  out_valid,
    output work_t out_work
);

    logic  [DivStages-1:0] valid_reg;
    work_t                 work_reg [DivStages];

    // Pass p splits off contracted slot 3-p, last slot first.
    for (genvar g = 0; g < DivStages; g++) begin : g_stage
        localparam int Pass = g / DivSteps;
        localparam int Step = g % DivSteps;
        localparam logic [1:0] Slot = 2'(DivPasses - 1 - Pass);

        work_t src;
        work_t work_next;
        logic  src_valid;

        if (g == 0) begin : g_first
            assign src       = in_work;
            assign src_valid = in_valid;
        end else begin : g_rest
            assign src       = work_reg[g-1];
            assign src_valid = valid_reg[g-1];
        end

        always_comb begin
            logic                  active;
            idx_t                  d;
            logic [FlatW+IdxW-1:0] res;
            active    = {1'b0, Slot} < count_at(cfg.rac, PosContract);
            d         = extent_at(cfg.lext, map_at(cfg.lmap, GrpContract, Slot));
            work_next = src;
            if (Step == 0) begin
                work_next.rem = '0;
            end
            res = div_step(work_next.num, work_next.rem, d);
            if (active) begin
                work_next.num = res[FlatW+IdxW-1:IdxW];
                work_next.rem = res[IdxW-1:0];
                if (Step == DivSteps - 1) begin
                    work_next.cidx[Slot] = res[IdxW-1:0];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[g] <= 1'b0;
            end else if (adv) begin
                valid_reg[g] <= src_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                work_reg[g] <= work_next;
            end
        end
    end

    assign out_valid = valid_reg[DivStages-1];
    assign out_work  = work_reg[DivStages-1];

endmodule

### rtl/todga_tile.sv
// ============================================================================
// todga_tile
// Four-stage tile number and in-tile face offset for one operand.
// ============================================================================
module todga_tile import todga_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  logic             in_valid,
    input  idx_vec_t         idx,
    input  logic [63:0]      ext,
    input  logic [31:0]      grid,
    input  logic [2:0]       rank,
    output logic             out_valid,
    output logic [TileW-1:0] tile,
    output logic [OffW-1:0]  offset
);

    logic [3:0]       valid_reg;
    logic [TileW-1:0] acc1_reg, acc2_reg, acc3_reg, acc4_reg;
    logic [TileW-1:0] acc1_next, acc2_next, acc3_next, acc4_next;
    idx_t             idx1_reg;
    logic             use_e1_reg;
    logic [10:0]      rowt1_reg, rowt2_reg, colt1_reg, colt2_reg, colt3_reg;
    logic [OffW-1:0]  off1_reg, off2_reg, off3_reg, off4_reg;
    idx_t             row, col;
    logic [OffW-1:0]  off_next;

    always_comb begin
        unique case (rank)
            3'd3:    begin row = idx[1]; col = idx[2]; end
            3'd4:    begin row = idx[2]; col = idx[3]; end
            default: begin row = idx[0]; col = idx[1]; end
        endcase
        off_next  = {row[4], col[4], row[3:0], col[3:0]};
        acc1_next = (rank > 3'd2) ? TileW'(idx[0]) : '0;
    end

    assign acc2_next = use_e1_reg
        ? TileW'(acc1_reg * extent_at(ext, 2'd1)) + TileW'(idx1_reg) : acc1_reg;
    assign acc3_next = TileW'(acc2_reg * grid[15:0]) + TileW'(rowt2_reg);
    assign acc4_next = TileW'(acc3_reg * grid[31:16]) + TileW'(colt3_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            acc1_reg   <= acc1_next;
            idx1_reg   <= idx[1];
            use_e1_reg <= rank > 3'd3;
            rowt1_reg  <= row[15:5];
            colt1_reg  <= col[15:5];
            off1_reg   <= off_next;
            acc2_reg   <= acc2_next;
            rowt2_reg  <= rowt1_reg;
            colt2_reg  <= colt1_reg;
            off2_reg   <= off1_reg;
            acc3_reg   <= acc3_next;
            colt3_reg  <= colt2_reg;
            off3_reg   <= off2_reg;
            acc4_reg   <= acc4_next;
            off4_reg   <= off3_reg;
        end
    end

    assign out_valid = valid_reg[3];
    assign tile      = acc4_reg;
    assign offset    = off4_reg;

endmodule

### rtl/tiled_dot_general_operand_address.sv
// ============================================================================
// tiled_dot_general_operand_address
// Builds left and right operand index tuples from an output index and a flat
// contraction position, and gives each operand's tile number and offset.
// ============================================================================
// Pipeline: 1 mapping stage, 24 divider stages, 4 tile arithmetic stages.
// Throughput: one beat per cycle; the whole pipeline holds while a result
// beat waits on m_tready, and the divider's 24 stages make up most of the depth.
// Reset (aresetn, synchronous, active low) clears all valid bits and loads
// the configuration registers with their default values.
module tiled_dot_general_operand_address import todga_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata: out_index_0, out_index_1, out_index_2, out_index_3, contract_flat
    input  logic [87:0] s_tdata,
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: left_tile, left_offset, right_tile, right_offset, 4 zero bits
    output logic [87:0] m_tdata
);

    cfg_t     cfg_reg;
    reg_idx_t reg_sel;
    logic     adv;

    // Registers sit at eight-byte strides; the low address bits are ignored.
    assign reg_sel = reg_idx_t'(paddr[5:3]);
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lext  <= 64'h0001_0001_0001_0001;
            cfg_reg.rext  <= 64'h0001_0001_0001_0001;
            cfg_reg.rac   <= 18'd18;
            cfg_reg.lmap  <= '0;
            cfg_reg.rmap  <= '0;
            cfg_reg.lgrid <= 32'h0001_0001;
            cfg_reg.rgrid <= 32'h0001_0001;
        end else if (psel && penable && pwrite) begin
            unique case (reg_sel)
                RegLeftExt:   cfg_reg.lext  <= pwdata;
                RegRightExt:  cfg_reg.rext  <= pwdata;
                RegRanks:     cfg_reg.rac   <= pwdata[17:0];
                RegLeftMap:   cfg_reg.lmap  <= pwdata[23:0];
                RegRightMap:  cfg_reg.rmap  <= pwdata[23:0];
                RegLeftGrid:  cfg_reg.lgrid <= pwdata[31:0];
                RegRightGrid: cfg_reg.rgrid <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            RegLeftExt:   prdata = cfg_reg.lext;
            RegRightExt:  prdata = cfg_reg.rext;
            RegRanks:     prdata = 64'(cfg_reg.rac);
            RegLeftMap:   prdata = 64'(cfg_reg.lmap);
            RegRightMap:  prdata = 64'(cfg_reg.rmap);
            RegLeftGrid:  prdata = 64'(cfg_reg.lgrid);
            RegRightGrid: prdata = 64'(cfg_reg.rgrid);
            default:      prdata = '0;
        endcase
    end

    // Every stage moves together; the final tile stage doubles as the output
    // register, so the pipeline advances whenever that register is free or
    // is being emptied in this cycle.
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    logic     map_valid, div_valid, lt_valid, rt_valid;
    work_t    map_work, div_work;
    idx_vec_t outi;
    idx_vec_t lidx, ridx;

    assign outi = s_tdata[63:0];

    todga_map u_map (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .outi      (outi),
        .flat      (s_tdata[87:64]),
        .cfg       (cfg_reg),
        .out_valid (map_valid),
        .out_work  (map_work)
    );

    todga_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (map_valid),
        .in_work   (map_work),
        .cfg       (cfg_reg),
        .out_valid (div_valid),
        .out_work  (div_work)
    );

    // Contracted indices overwrite batch and outer ones; later slots win.
    always_comb begin
        logic [2:0] ccount;
        ccount = count_at(cfg_reg.rac, PosContract);
        lidx   = div_work.lidx;
        ridx   = div_work.ridx;
        for (int i = 0; i < NumDims; i++) begin
            if (3'(i) < ccount) begin
                lidx[map_at(cfg_reg.lmap, GrpContract, 2'(i))] = div_work.cidx[i];
                ridx[map_at(cfg_reg.rmap, GrpContract, 2'(i))] = div_work.cidx[i];
            end
        end
    end

    logic [TileW-1:0] left_tile, right_tile;
    logic [OffW-1:0]  left_offset, right_offset;

    todga_tile u_left (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (div_valid),
        .idx       (lidx),
        .ext       (cfg_reg.lext),
        .grid      (cfg_reg.lgrid),
        .rank      (rank_at(cfg_reg.rac, PosLeftRank)),
        .out_valid (lt_valid),
        .tile      (left_tile),
        .offset    (left_offset)
    );

    todga_tile u_right (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (div_valid),
        .idx       (ridx),
        .ext       (cfg_reg.rext),
        .grid      (cfg_reg.rgrid),
        .rank      (rank_at(cfg_reg.rac, PosRightRank)),
        .out_valid (rt_valid),
        .tile      (right_tile),
        .offset    (right_offset)
    );

    assign m_tvalid = lt_valid && rt_valid;
    assign m_tdata  = {4'b0, right_offset, right_tile, left_offset, left_tile};

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Operand address generator testbench
// Drives output index tuples and flat contraction positions through the
// stream port under several register settings, predicts each operand's tile
// number and in-tile offset, and compares every result beat in order.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import todga_pkg::*;

    // Expected address pair of one result beat.
    typedef struct packed {
        logic [31:0] ltile;
        logic [9:0]  loff;
        logic [31:0] rtile;
        logic [9:0]  roff;
    } addr_pair_t;

    // Holds the register copy, predicts the address pairs and checks them.
    class address_scoreboard;
        logic [63:0] lext, rext;
        logic [17:0] rac;
        logic [23:0] lmap, rmap;
        logic [31:0] lgrid, rgrid;
        addr_pair_t  pending[$];
        int          mismatches;

        function new();
            lext = 64'h0001_0001_0001_0001;
            rext = 64'h0001_0001_0001_0001;
            rac = 18'd18;
            lmap = '0;
            rmap = '0;
            lgrid = 32'h0001_0001;
            rgrid = 32'h0001_0001;
            mismatches = 0;
        endfunction

        function void set_reg(reg_idx_t r, logic [63:0] v);
            case (r)
                RegLeftExt:   lext = v;
                RegRightExt:  rext = v;
                RegRanks:     rac = v[17:0];
                RegLeftMap:   lmap = v[23:0];
                RegRightMap:  rmap = v[23:0];
                RegLeftGrid:  lgrid = v[31:0];
                RegRightGrid: rgrid = v[31:0];
                default: ;
            endcase
        endfunction

        function int unsigned ext_of(logic [63:0] e, int unsigned d);
            int unsigned x;
            if (d >= 4) return 1;
            x = (e >> (16 * d)) & 16'hFFFF;
            return (x == 0) ? 1 : x;
        endfunction

        function int unsigned cnt_of(int p);
            int unsigned c;
            c = (rac >> (3 * p)) & 3'h7;
            return (c > 4) ? 4 : c;
        endfunction

        function int unsigned rank_of(int p);
            int unsigned r;
            r = (rac >> (3 * p)) & 3'h7;
            if (r < 2) r = 2;
            if (r > RankLimit) r = RankLimit;
            return r;
        endfunction

        function int unsigned slot_dim(logic [23:0] m, int g, int s);
            return (m >> (2 * (g * 4 + s))) & 2'h3;
        endfunction

        function void tile_of(int unsigned ix[4], logic [63:0] e, int unsigned rk,
                              logic [31:0] g, output logic [31:0] t,
                              output logic [9:0] o);
            logic [31:0] acc;
            int unsigned row, col, r, c;
            acc = 0;
            row = ix[rk - 2];
            col = ix[rk - 1];
            for (int d = 0; d + 2 < rk; d++) acc = acc * ext_of(e, d) + ix[d];
            acc = acc * g[15:0] + (row >> 5);
            acc = acc * g[31:16] + (col >> 5);
            t = acc;
            r = row & 31;
            c = col & 31;
            o = (((r >> 4) * 2 + (c >> 4)) << 8) + ((r & 15) << 4) + (c & 15);
        endfunction

        function void note_input(logic [87:0] beat);
            int unsigned outi[4], li[4], ri[4], ci[4];
            int unsigned nb, nlo, nro, nc, od, flat, e;
            addr_pair_t p;
            for (int i = 0; i < 4; i++) begin
                outi[i] = beat[16 * i +: 16];
                li[i] = 0;
                ri[i] = 0;
                ci[i] = 0;
            end
            flat = beat[64 +: 24];
            nb = cnt_of(PosBatch);
            nlo = cnt_of(PosLeftOut);
            nro = cnt_of(PosRightOut);
            nc = cnt_of(PosContract);
            for (int i = 0; i < nb; i++) begin
                li[slot_dim(lmap, GrpBatch, i)] = outi[i];
                ri[slot_dim(rmap, GrpBatch, i)] = outi[i];
            end
            od = nb;
            // Outer slots past the fourth output dimension read zero.
            for (int i = 0; i < nlo; i++, od++)
                li[slot_dim(lmap, GrpOuter, i)] = (od < 4) ? outi[od] : 0;
            for (int i = 0; i < nro; i++, od++)
                ri[slot_dim(rmap, GrpOuter, i)] = (od < 4) ? outi[od] : 0;
            for (int i = nc; i > 0; i--) begin
                e = ext_of(lext, slot_dim(lmap, GrpContract, i - 1));
                ci[i - 1] = flat % e;
                flat = flat / e;
            end
            for (int i = 0; i < nc; i++) begin
                li[slot_dim(lmap, GrpContract, i)] = ci[i];
                ri[slot_dim(rmap, GrpContract, i)] = ci[i];
            end
            tile_of(li, lext, rank_of(PosLeftRank), lgrid, p.ltile, p.loff);
            tile_of(ri, rext, rank_of(PosRightRank), rgrid, p.rtile, p.roff);
            pending.push_back(p);
        endfunction

        function void check_result(logic [87:0] beat);
            addr_pair_t x, a;
            a.ltile = beat[31:0];
            a.loff = beat[41:32];
            a.rtile = beat[73:42];
            a.roff = beat[83:74];
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", beat);
                return;
            end
            x = pending.pop_front();
            if (x != a) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected lt %h lo %h rt %h ro %h, got %h %h %h %h",
                             x.ltile, x.loff, x.rtile, x.roff,
                             a.ltile, a.loff, a.rtile, a.roff);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // s_tdata: out_index_0..3 (16 bits each), contract_flat (24 bits)
    logic [87:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // m_tdata: left_tile, left_offset, right_tile, right_offset, 4 zero bits
    logic [87:0] m_tdata;

    address_scoreboard board = new();
    int          idle_cycles = 0;

    tiled_dot_general_operand_address dut (.*);

    always #5 aclk = ~aclk;

    // The receiver draws a random stall before taking each beat.
    // A stall of zero keeps tready up, so that bursts run through.
    initial begin : result_side
        int w;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            if (w > 0) begin
                m_tready <= 1'b0;
                repeat (w) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            board.check_result(m_tdata);
        end
    end

    // The watchdog counts cycles in which no beat of either stream moves.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > 2000) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // A register write: setup, access, then idle.
    task automatic write_reg(reg_idx_t r, logic [63:0] v);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 6'(8 * r);
        pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        board.set_reg(r, v);
        @(posedge aclk);
    endtask

    // Sends one beat after a random gap; valid stays up across back-to-back beats.
    task automatic send_beat(logic [87:0] d, bit nogap);
        int w;
        w = nogap ? 0 : $urandom_range(0, 4);
        if (w > 0) begin
            s_tvalid <= 1'b0;
            repeat (w) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        do @(posedge aclk); while (!s_tready);
        board.note_input(d);
    endtask

    // The block is idle once nothing is expected and the pipeline has drained.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    function automatic logic [87:0] rand_beat();
        return {$urandom_range(0, 2) == 0 ? 24'($urandom) : 24'($urandom_range(0, 4095)),
                16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
    endfunction

    // A random setting; small extents keep contraction splits interesting.
    task automatic random_setting();
        logic [63:0] e;
        for (int i = 0; i < 4; i++) e[16 * i +: 16] = ($urandom_range(0, 3) == 0) ?
            16'($urandom) : 16'($urandom_range(0, 40));
        write_reg(RegLeftExt, e);
        for (int i = 0; i < 4; i++) e[16 * i +: 16] = ($urandom_range(0, 3) == 0) ?
            16'($urandom) : 16'($urandom_range(0, 40));
        write_reg(RegRightExt, e);
        write_reg(RegRanks, 64'($urandom_range(0, 18'h3FFFF)));
        write_reg(RegLeftMap, 64'($urandom));
        write_reg(RegRightMap, 64'($urandom));
        write_reg(RegLeftGrid, 64'($urandom));
        write_reg(RegRightGrid, 64'($urandom));
    endtask

    initial begin : stimulus
        logic [87:0] d;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed beats under the reset setting, then with ranks and counts
        // at their extremes, zero extents, and full and empty tile grids.
        send_beat('0, 0);
        send_beat({88{1'b1}}, 0);
        send_beat({24'h000000, 16'd31, 16'd16, 16'd33, 16'd15}, 0);
        drain();
        write_reg(RegLeftExt, 64'h0000_0003_0005_0007);
        write_reg(RegRightExt, 64'hFFFF_0000_0002_FFFF);
        // Ranks above the limit and counts above four saturate.
        write_reg(RegRanks, 64'h3FFFF);
        write_reg(RegLeftMap, 64'hE4_E4_E4);
        write_reg(RegRightMap, 64'h1B_4E_E4);
        write_reg(RegLeftGrid, 64'hFFFF_FFFF);
        write_reg(RegRightGrid, 64'h0000_0000);
        for (int i = 0; i < 8; i++) send_beat(rand_beat(), i[0]);
        send_beat({88{1'b1}}, 0);
        send_beat('0, 1);
        drain();
        // Small ranks, outer slots running past the output dimensions.
        write_reg(RegRanks, 64'({3'd1, 3'd3, 3'd4, 3'd2, 3'd0, 3'd1}));
        for (int i = 0; i < 8; i++) send_beat(rand_beat(), 0);
        drain();

        for (int phase = 0; phase < 12; phase++) begin
            random_setting();
            for (int i = 0; i < 95; i++) begin
                d = rand_beat();
                send_beat(d, (phase % 3) == 0);
            end
            drain();
        end
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule
